// ===== rtl/sfc_pkg.sv =====
// static frame classifier package: payload structs, register map, gray coefficients
// no dependencies; used by sfc_front, sfc_back and the top level
`default_nettype none

package sfc_pkg;

  // input request payload
  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       end_of_image;
  } in_item_t;

  // result request payload
  typedef struct packed {
    logic [23:0] frame_index;
    logic        is_static;
    logic        size_error;
  } out_item_t;

  // per-pixel control and gray value handed from front to back
  typedef struct packed {
    logic       classify;
    logic       last;
    logic       in_range;
    logic       size_error;
    logic [7:0] gray;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

  // opcodes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // register map, selected by paddr[2]
  localparam int   PADDR_W    = 3;
  localparam logic REG_BG_THR = 1'b0;
  localparam logic REG_MV_THR = 1'b1;

  localparam logic [7:0] BG_THR_RESET = 8'd10;
  localparam logic [7:0] MV_THR_RESET = 8'd3;

  // fixed-point luma, 14 fractional bits, rounded
  localparam int          GRAY_ACC_W  = 22;
  localparam logic [21:0] GRAY_R_COEF = 22'd4899;
  localparam logic [21:0] GRAY_G_COEF = 22'd9617;
  localparam logic [21:0] GRAY_B_COEF = 22'd1868;
  localparam logic [21:0] GRAY_ROUND  = 22'd8192;

  localparam int QUEUE_DEPTH = 4;
  localparam int FRAME_CNT_W = 24;

endpackage

`default_nettype wire

// ===== rtl/sfc_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// returns old data when reading the address being written; no dependencies
`default_nettype none

module sfc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfc_queue.sv =====
// short first-in first-out queue between front and back
// no dependencies
`default_nettype none

module sfc_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfc_front.sv =====
// front end: accepts pixel requests, converts to gray, tracks position and overflow
// depends on sfc_pkg
`default_nettype none

module sfc_front #(
  parameter int  FRAME_PIXELS = 262144,
  localparam int AW           = $clog2(FRAME_PIXELS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sfc_pkg::in_item_t  in_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output sfc_pkg::item_ctl_t      q_ctl,
  output logic      [AW-1:0]      q_addr
);

  localparam int POS_W = $clog2(FRAME_PIXELS + 1);

  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [sfc_pkg::GRAY_ACC_W-1:0] gray_acc;
  logic                           in_range;
  logic                           size_err;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // rounded fixed-point luma
  assign gray_acc = sfc_pkg::GRAY_R_COEF * sfc_pkg::GRAY_ACC_W'(in_data.pixel_red)
                  + sfc_pkg::GRAY_G_COEF * sfc_pkg::GRAY_ACC_W'(in_data.pixel_green)
                  + sfc_pkg::GRAY_B_COEF * sfc_pkg::GRAY_ACC_W'(in_data.pixel_blue)
                  + sfc_pkg::GRAY_ROUND;

  assign in_range = (pos_r < POS_W'(FRAME_PIXELS));
  assign size_err = ovf_r || !in_range;

  // item handed to the back end
  always_comb begin
    q_ctl.classify   = (in_data.opcode == sfc_pkg::OP_CLASSIFY);
    q_ctl.last       = in_data.end_of_image;
    q_ctl.in_range   = in_range;
    q_ctl.size_error = size_err;
    q_ctl.gray       = gray_acc[21:14];
    q_addr           = pos_r[AW-1:0];
  end

  // position and overflow tracking, shared by both opcodes
  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_data.end_of_image) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        ovf_nxt = size_err;
        if (in_range) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfc_back.sv =====
// back end: store access, difference sums, verdict and result register
// depends on sfc_pkg and sfc_ram
`default_nettype none

module sfc_back #(
  parameter int  FRAME_PIXELS = 262144,
  localparam int AW           = $clog2(FRAME_PIXELS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_not_empty,
  output logic                    q_pop,
  input  wire sfc_pkg::item_ctl_t q_ctl,
  input  wire logic [AW-1:0]      q_addr,
  input  wire logic [7:0]         bg_thr,
  input  wire logic [7:0]         mv_thr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfc_pkg::out_item_t      out_data
);

  localparam int SUM_W = $clog2(FRAME_PIXELS * 255 + 1);
  localparam int CNT_W = sfc_pkg::FRAME_CNT_W;

  logic               adv;

  // read stage registers
  logic               b1_valid_r;
  sfc_pkg::item_ctl_t b1_ctl_r;
  logic [AW-1:0]      b1_addr_r;
  logic               fwd_bg_r, fwd_prev_r;
  logic [7:0]         fwd_data_r;

  // accumulate stage
  logic [7:0]         bg_rdata, prev_rdata;
  logic [7:0]         bg_ref, prev_ref;
  logic [7:0]         diff_bg, diff_prev;
  logic               bg_we, prev_we, acc_en;
  logic [SUM_W-1:0]   bg_sum_r, prev_sum_r;
  logic [SUM_W-1:0]   bg_sum_nxt, prev_sum_nxt;

  // verdict stage
  logic               b2_valid_r;
  logic [SUM_W-1:0]   fin_bg_r, fin_prev_r;
  logic               b2_size_err_r;
  logic [SUM_W-1:0]   bg_lim_r, mv_lim_r;
  logic               prev_static_r;
  logic [CNT_W-1:0]   frame_cnt_r;
  logic               verdict;

  // result register
  logic               out_valid_r;
  sfc_pkg::out_item_t out_data_r;

  // whole back end moves together when the result register can take a request
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_not_empty;

  // background and previous-frame stores
  assign bg_we   = adv && b1_valid_r && b1_ctl_r.in_range && !b1_ctl_r.classify;
  assign prev_we = adv && b1_valid_r && b1_ctl_r.in_range && b1_ctl_r.classify;

  sfc_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_bg_ram (
    .clk   (clk),
    .we    (bg_we),
    .waddr (b1_addr_r),
    .wdata (b1_ctl_r.gray),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (bg_rdata)
  );

  sfc_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (b1_addr_r),
    .wdata (b1_ctl_r.gray),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (prev_rdata)
  );

  // read stage, with bypass of a write landing in the same cycle as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      fwd_bg_r   <= 1'b0;
      fwd_prev_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r <= q_not_empty;
      fwd_bg_r   <= bg_we && (b1_addr_r == q_addr);
      fwd_prev_r <= prev_we && (b1_addr_r == q_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_ctl_r   <= q_ctl;
      b1_addr_r  <= q_addr;
      fwd_data_r <= b1_ctl_r.gray;
    end
  end

  // absolute differences against both stores
  always_comb begin
    bg_ref    = fwd_bg_r ? fwd_data_r : bg_rdata;
    prev_ref  = fwd_prev_r ? fwd_data_r : prev_rdata;
    diff_bg   = (b1_ctl_r.gray > bg_ref) ? b1_ctl_r.gray - bg_ref : bg_ref - b1_ctl_r.gray;
    diff_prev = (b1_ctl_r.gray > prev_ref) ? b1_ctl_r.gray - prev_ref
                                           : prev_ref - b1_ctl_r.gray;
    acc_en    = b1_ctl_r.in_range && b1_ctl_r.classify;
    bg_sum_nxt   = acc_en ? bg_sum_r + SUM_W'(diff_bg) : bg_sum_r;
    prev_sum_nxt = acc_en ? prev_sum_r + SUM_W'(diff_prev) : prev_sum_r;
  end

  // running sums, cleared at the end of every image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_sum_r   <= '0;
      prev_sum_r <= '0;
      b2_valid_r <= 1'b0;
    end else if (adv) begin
      b2_valid_r <= b1_valid_r && b1_ctl_r.last && b1_ctl_r.classify;
      if (b1_valid_r) begin
        if (b1_ctl_r.last) begin
          bg_sum_r   <= '0;
          prev_sum_r <= '0;
        end else begin
          bg_sum_r   <= bg_sum_nxt;
          prev_sum_r <= prev_sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_bg_r      <= bg_sum_nxt;
      fin_prev_r    <= prev_sum_nxt;
      b2_size_err_r <= b1_ctl_r.size_error;
    end
  end

  // frame limits follow the thresholds, which the user must change only while idle (unenforced)
  always_ff @(posedge clk) begin
    bg_lim_r <= SUM_W'(FRAME_PIXELS) * SUM_W'(bg_thr);
    mv_lim_r <= SUM_W'(FRAME_PIXELS) * SUM_W'(mv_thr);
  end

  // static verdict
  assign verdict = (fin_bg_r < bg_lim_r) || (prev_static_r && (fin_prev_r < mv_lim_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      prev_static_r <= 1'b0;
      frame_cnt_r   <= '0;
    end else if (adv) begin
      out_valid_r <= b2_valid_r;
      if (b2_valid_r) begin
        prev_static_r <= verdict;
        frame_cnt_r   <= frame_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b2_valid_r) begin
      out_data_r.frame_index <= frame_cnt_r;
      out_data_r.is_static   <= verdict;
      out_data_r.size_error  <= b2_size_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/static_frame_classifier_unit.sv =====
// top level of the static frame classifier: register port, front, queue, back
// depends on sfc_pkg, sfc_front, sfc_queue, sfc_back (and sfc_ram through sfc_back)
`default_nettype none

// Takes one BGR pixel request per clock in raster order and sustains one per
// clock unless a waiting result stalls the back end. Load requests (opcode 0)
// store the gray pixel as background; classify requests (opcode 1) accumulate
// absolute differences against the background and the previous frame, and
// the classify request marked end_of_image yields one result with the frame
// index, the static verdict and size_error. The result follows the store read
// as the last pixel leaves the queue, the sum update, then the verdict into
// the output register. The rate is set by the two stores, each a ram with one
// write and one registered read port, read once and written at most once per
// pixel. The stores have no reset and no clearing pass; entries must be written
// before they are compared. The front keeps taking pixels while a result waits,
// until the four-entry queue fills. Thresholds (byte address 0: background, 4:
// motion): the user must write them only while the block is idle; unenforced.
module static_frame_classifier_unit #(
  parameter int FRAME_PIXELS = 262144
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pixel requests
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire sfc_pkg::in_item_t           in_data,
  // result requests
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output sfc_pkg::out_item_t               out_data,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sfc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int AW = $clog2(FRAME_PIXELS);
  localparam int QW = sfc_pkg::CTL_W + AW;

  logic               q_push, q_pop, q_full, q_not_empty;
  sfc_pkg::item_ctl_t f_ctl, b_ctl;
  logic [AW-1:0]      f_addr, b_addr;
  logic [QW-1:0]      q_rd;
  logic [7:0]         bg_thr_r, mv_thr_r;
  logic               reg_wr;

  // threshold registers
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_thr_r <= sfc_pkg::BG_THR_RESET;
      mv_thr_r <= sfc_pkg::MV_THR_RESET;
    end else if (reg_wr) begin
      case (paddr[2])
        sfc_pkg::REG_BG_THR: bg_thr_r <= pwdata[7:0];
        sfc_pkg::REG_MV_THR: mv_thr_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sfc_pkg::REG_BG_THR: prdata = {24'd0, bg_thr_r};
      sfc_pkg::REG_MV_THR: prdata = {24'd0, mv_thr_r};
      default:             prdata = '0;
    endcase
  end

  sfc_front #(.FRAME_PIXELS(FRAME_PIXELS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctl    (f_ctl),
    .q_addr   (f_addr)
  );

  sfc_queue #(.WIDTH(QW), .DEPTH(sfc_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   ({f_ctl, f_addr}),
    .pop       (q_pop),
    .rd_data   (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign b_ctl  = sfc_pkg::item_ctl_t'(q_rd[QW-1:AW]);
  assign b_addr = q_rd[AW-1:0];

  sfc_back #(.FRAME_PIXELS(FRAME_PIXELS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_ctl       (b_ctl),
    .q_addr      (b_addr),
    .bg_thr      (bg_thr_r),
    .mv_thr      (mv_thr_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
